/* sv/mcqd_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and the transition table of the quadrature decoder
// no dependencies; used by every module of the block

package mcqd_pkg;

	// item kinds carried in the input tuser
	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_CLEAR  = 2'd1,
		KIND_READ   = 2'd2,
		KIND_RSVD   = 2'd3
	} kind_t;

	// direction codes kept as the last step of a channel
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd3;

	// both pins changed at once
	localparam logic [1:0] DELTA_SKIP = 2'd3;

	localparam int CHAN_W  = 2;
	localparam int AB_W    = 2;
	localparam int COUNT_W = 32;

	// step direction indexed by {previous ab, new ab}
	localparam logic [1:0] STEP_DIR [16] = '{
		DIR_NONE, DIR_UP,   DIR_DOWN, DIR_NONE,
		DIR_DOWN, DIR_NONE, DIR_NONE, DIR_UP,
		DIR_UP,   DIR_NONE, DIR_NONE, DIR_DOWN,
		DIR_NONE, DIR_DOWN, DIR_UP,   DIR_NONE
	};

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [AB_W-1:0]    prev_ab;
		logic [1:0]         last_dir;
	} chan_state_t;

endpackage

/* sv/mcqd_chan_bank.sv */
`timescale 1ns / 1ps
// per-channel decoder state: count, previous ab and last direction
// depends on mcqd_pkg

module mcqd_chan_bank #(
	parameter int CHANNELS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [mcqd_pkg::CHAN_W-1:0] sel_ch,
	output logic                        sel_hit,
	output mcqd_pkg::chan_state_t       sel_state,
	input  logic                        wr_en,
	input  mcqd_pkg::chan_state_t       wr_state
);

	mcqd_pkg::chan_state_t state_q [CHANNELS];
	logic [CHANNELS-1:0] hit;

	always_comb begin
		sel_state = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			hit[i] = (int'(sel_ch) == i);
			if (hit[i]) begin
				sel_state = state_q[i];
			end
		end
	end

	assign sel_hit = |hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				state_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (wr_en && hit[i]) begin
					state_q[i] <= wr_state;
				end
			end
		end
	end

endmodule

/* sv/mcqd_step.sv */
`timescale 1ns / 1ps
// next-state and result logic for one item on one channel
// depends on mcqd_pkg

module mcqd_step (
	input  mcqd_pkg::kind_t                kind,
	input  logic [mcqd_pkg::AB_W-1:0]      ab,
	input  logic                           enabled,
	input  logic                           hit,
	input  mcqd_pkg::chan_state_t          cur_state,
	output mcqd_pkg::chan_state_t          nxt_state,
	output logic                           upd,
	output logic                           progressed,
	output logic [mcqd_pkg::COUNT_W-1:0]   position
);

	logic [mcqd_pkg::AB_W-1:0] delta;
	logic [1:0]                tdir;
	logic [1:0]                use_dir;
	logic                      do_step;

	always_comb begin
		delta      = cur_state.prev_ab ^ ab;
		tdir       = mcqd_pkg::STEP_DIR[{cur_state.prev_ab, ab}];
		nxt_state  = cur_state;
		upd        = 1'b0;
		progressed = 1'b0;
		do_step    = 1'b0;
		use_dir    = cur_state.last_dir;
		unique case (kind)
			mcqd_pkg::KIND_SAMPLE: begin
				if (enabled && hit && delta != '0) begin
					upd               = 1'b1;
					nxt_state.prev_ab = ab;
					if (delta == mcqd_pkg::DELTA_SKIP) begin
						// skipped state: repeat last step
						do_step    = 1'b1;
						progressed = 1'b1;
					end else if (tdir != mcqd_pkg::DIR_NONE) begin
						do_step            = 1'b1;
						use_dir            = tdir;
						nxt_state.last_dir = tdir;
						progressed         = 1'b1;
					end
				end
			end
			mcqd_pkg::KIND_CLEAR: begin
				if (hit) begin
					upd       = 1'b1;
					nxt_state = '{count: '0, prev_ab: ab, last_dir: mcqd_pkg::DIR_NONE};
				end
			end
			mcqd_pkg::KIND_READ, mcqd_pkg::KIND_RSVD: begin
			end
			default: begin
			end
		endcase
		if (do_step) begin
			if (use_dir == mcqd_pkg::DIR_UP) begin
				nxt_state.count = cur_state.count + 32'd1;
			end else if (use_dir == mcqd_pkg::DIR_DOWN) begin
				nxt_state.count = cur_state.count - 32'd1;
			end
		end
		position = hit ? nxt_state.count : '0;
	end

endmodule

/* sv/multi_channel_quadrature_decoder_top.sv */
`timescale 1ns / 1ps
// top level of the multi-channel x4 quadrature decoder
// depends on mcqd_pkg, mcqd_chan_bank and mcqd_step
//
// usage
//   s_* stream: one word per item; s_tuser is the item kind (sample, clear,
//     read), s_tdata carries the channel and the sampled A/B pins
//   m_* stream: exactly one word per accepted item, in order, holding the
//     channel, its signed count after the item and a progress flag
//   cfg_*: write of the channel enable mask, always ready; write only
//     while the block is idle
// an accepted item passes the input register, then the result register, to m_*
// throughput: one item per cycle while m_tready keeps the output moving, also
//   back to back on the same channel, since the state of a channel is updated
//   in the same edge that moves the result into the output register
// stall: while m_tready is low the output register holds; one more item
//   can wait in the input register, then s_tready drops
// reset: counts, previous ab, last directions and the enable mask clear,
//   both pipeline registers empty

module multi_channel_quadrature_decoder_top #(
	parameter int CHANNELS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [1:0] channel, [3:2] ab, [7:4] zero
	input  logic [1:0]  s_tuser,   // [1:0] kind
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [1:0] channel_out, [33:2] position, [39:34] zero
	output logic [0:0]  m_tuser,   // [0] progressed
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data   // [3:0] channel_enable
);

	// input register
	logic                          valid_s1;
	mcqd_pkg::kind_t               kind_s1;
	logic [mcqd_pkg::CHAN_W-1:0]   ch_s1;
	logic [mcqd_pkg::AB_W-1:0]     ab_s1;

	// result register
	logic                          out_valid_q;
	logic [mcqd_pkg::CHAN_W-1:0]   out_ch_q;
	logic [mcqd_pkg::COUNT_W-1:0]  out_pos_q;
	logic                          out_prog_q;

	logic [3:0]                    enable_q;

	logic                          advance;
	logic                          s_accept;
	logic                          sel_hit;
	mcqd_pkg::chan_state_t         cur_state;
	mcqd_pkg::chan_state_t         nxt_state;
	logic                          upd;
	logic                          progressed;
	logic [mcqd_pkg::COUNT_W-1:0]  position;

	// the input word moves on when the result register frees up
	assign advance   = !out_valid_q || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign s_accept  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= '0;
		end else if (cfg_valid) begin
			enable_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload of the input register, no reset
	always_ff @(posedge clk) begin
		if (s_accept) begin
			kind_s1 <= mcqd_pkg::kind_t'(s_tuser);
			ch_s1   <= s_tdata[1:0];
			ab_s1   <= s_tdata[3:2];
		end
	end

	mcqd_chan_bank #(
		.CHANNELS (CHANNELS)
	) u_bank (
		.clk       (clk),
		.arst_n    (arst_n),
		.sel_ch    (ch_s1),
		.sel_hit   (sel_hit),
		.sel_state (cur_state),
		.wr_en     (valid_s1 && advance && upd),
		.wr_state  (nxt_state)
	);

	mcqd_step u_step (
		.kind       (kind_s1),
		.ab         (ab_s1),
		.enabled    (enable_q[ch_s1]),
		.hit        (sel_hit),
		.cur_state  (cur_state),
		.nxt_state  (nxt_state),
		.upd        (upd),
		.progressed (progressed),
		.position   (position)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// result payload, no reset
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_ch_q   <= ch_s1;
			out_pos_q  <= position;
			out_prog_q <= progressed;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_pos_q, out_ch_q};
	assign m_tuser  = out_prog_q;

`ifndef SYNTH
	// a cleared channel reports a zero count and no progress
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && kind_s1 == mcqd_pkg::KIND_CLEAR
		|=> m_tvalid && out_pos_q == '0 && !out_prog_q)
		else $error("clear did not report a zero count");

	// only samples can report progress
	a_prog_sample: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && kind_s1 != mcqd_pkg::KIND_SAMPLE
		|=> !out_prog_q)
		else $error("progress flagged on a non-sample item");

	// an empty output stage never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled with empty output register");

	// state only changes when an item leaves the input register
	a_bank_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && advance) |=> $stable(u_bank.state_q[0]))
		else $error("channel state changed without an item");
`endif

endmodule

/* sim/multi_channel_quadrature_decoder_top_tb.sv */
`timescale 1ns / 1ps
// self-checking bench for the multi-channel x4 quadrature decoder: a typed-in directed table,
// then random encoder walks under several enable masks, checked against a local decoder model
// depends on mcqd_pkg and multi_channel_quadrature_decoder_top

module multi_channel_quadrature_decoder_top_tb;

	localparam int N_CHAN       = 4;
	localparam int LIMIT_CYCLES = 200_000;
	localparam int PHASE_WORDS  = 35;
	localparam int MAX_PRINTS   = 40;

	// last step kept per channel
	typedef enum logic [1:0] {
		HEAD_NONE = 2'd0,
		HEAD_UP   = 2'd1,
		HEAD_DOWN = 2'd3
	} heading_t;

	// pin change patterns
	localparam logic [1:0] NO_CHANGE = 2'b00;
	localparam logic [1:0] BOTH_PINS = 2'b11;

	// count step for {previous ab, new ab}
	localparam int STEP_OF [16] = '{
		0,  1, -1,  0,
		-1, 0,  0,  1,
		1,  0,  0, -1,
		0, -1,  1,  0
	};

	// pin states in forward order
	localparam logic [1:0] GRAY [4] = '{2'b00, 2'b01, 2'b11, 2'b10};

	typedef struct packed {
		logic [1:0]         chan;
		logic signed [31:0] position;
		logic               progressed;
	} decode_word_t;

	typedef struct packed {
		bit                 load;        // write mask before this word
		logic [3:0]         mask;
		mcqd_pkg::kind_t    kind;
		logic [1:0]         chan;
		logic [1:0]         ab;
		logic signed [31:0] position;
		bit                 progressed;
	} directed_row_t;

	// hand-worked rows: disabled reads, forward and reverse walks, double skips with and
	// without a remembered step, clear, read, reserved kind, wrap below zero
	localparam directed_row_t DIRECTED [25] = '{
		'{1'b0, 4'h0, mcqd_pkg::KIND_READ,   2'd0, 2'd0,  32'sd0, 1'b0},
		'{1'b0, 4'h0, mcqd_pkg::KIND_SAMPLE, 2'd1, 2'd1,  32'sd0, 1'b0},
		'{1'b1, 4'hF, mcqd_pkg::KIND_SAMPLE, 2'd0, 2'd1,  32'sd1, 1'b1},
		'{1'b0, 4'h0, mcqd_pkg::KIND_SAMPLE, 2'd0, 2'd3,  32'sd2, 1'b1},
		'{1'b0, 4'h0, mcqd_pkg::KIND_SAMPLE, 2'd0, 2'd3,  32'sd2, 1'b0},
		'{1'b0, 4'h0, mcqd_pkg::KIND_SAMPLE, 2'd0, 2'd0,  32'sd3, 1'b1},
		'{1'b0, 4'h0, mcqd_pkg::KIND_SAMPLE, 2'd0, 2'd2,  32'sd2, 1'b1},
		'{1'b0, 4'h0, mcqd_pkg::KIND_SAMPLE, 2'd0, 2'd1,  32'sd1, 1'b1},
		'{1'b0, 4'h0, mcqd_pkg::KIND_CLEAR,  2'd0, 2'd3,  32'sd0, 1'b0},
		'{1'b0, 4'h0, mcqd_pkg::KIND_SAMPLE, 2'd0, 2'd0,  32'sd0, 1'b1},
		'{1'b0, 4'h0, mcqd_pkg::KIND_SAMPLE, 2'd1, 2'd2, -32'sd1, 1'b1},
		'{1'b0, 4'h0, mcqd_pkg::KIND_SAMPLE, 2'd1, 2'd3, -32'sd2, 1'b1},
		'{1'b0, 4'h0, mcqd_pkg::KIND_READ,   2'd1, 2'd0, -32'sd2, 1'b0},
		'{1'b0, 4'h0, mcqd_pkg::KIND_RSVD,   2'd1, 2'd3, -32'sd2, 1'b0},
		'{1'b0, 4'h0, mcqd_pkg::KIND_CLEAR,  2'd2, 2'd2,  32'sd0, 1'b0},
		'{1'b0, 4'h0, mcqd_pkg::KIND_SAMPLE, 2'd2, 2'd3, -32'sd1, 1'b1},
		'{1'b0, 4'h0, mcqd_pkg::KIND_SAMPLE, 2'd2, 2'd1, -32'sd2, 1'b1},
		'{1'b0, 4'h0, mcqd_pkg::KIND_SAMPLE, 2'd2, 2'd0, -32'sd3, 1'b1},
		'{1'b0, 4'h0, mcqd_pkg::KIND_SAMPLE, 2'd2, 2'd2, -32'sd4, 1'b1},
		'{1'b0, 4'h0, mcqd_pkg::KIND_SAMPLE, 2'd3, 2'd1,  32'sd1, 1'b1},
		'{1'b0, 4'h0, mcqd_pkg::KIND_SAMPLE, 2'd3, 2'd3,  32'sd2, 1'b1},
		'{1'b0, 4'h0, mcqd_pkg::KIND_SAMPLE, 2'd3, 2'd2,  32'sd3, 1'b1},
		'{1'b0, 4'h0, mcqd_pkg::KIND_SAMPLE, 2'd3, 2'd0,  32'sd4, 1'b1},
		'{1'b1, 4'h7, mcqd_pkg::KIND_CLEAR,  2'd3, 2'd1,  32'sd0, 1'b0},
		'{1'b0, 4'h0, mcqd_pkg::KIND_SAMPLE, 2'd3, 2'd0,  32'sd0, 1'b0}
	};

	// enable mask of each random phase; phase 2 draws its own
	localparam logic [3:0] PHASE_MASK [8] = '{4'hF, 4'h0, 4'h6, 4'h5, 4'hA, 4'hF, 4'h3, 4'hF};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // [1:0] channel, [3:2] ab, [7:4] zero
	logic [1:0]  s_tuser;    // [1:0] kind
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;    // [1:0] channel_out, [33:2] position, [39:34] zero
	logic [0:0]  m_tuser;    // [0] progressed
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_data;   // [3:0] channel_enable

	// decoder model state, updated at each accepted word
	logic [31:0] enc_count   [N_CHAN];
	logic [1:0]  enc_prev_ab [N_CHAN];
	heading_t    enc_heading [N_CHAN];
	logic [3:0]  enc_enable;

	decode_word_t pending_words [$];   // expected result words, oldest first
	int           mismatches;
	int           cycle_count;
	bit           full_rate;           // no gaps and no stalls in this phase

	multi_channel_quadrature_decoder_top #(
		.CHANNELS (N_CHAN)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// decoder model: applies one word and returns the result it must produce
	function automatic decode_word_t decode_step(mcqd_pkg::kind_t kind, logic [1:0] chan,
	                                             logic [1:0] ab);
		decode_word_t w;
		logic [1:0]   moved;
		int           slope;
		w.chan       = chan;
		w.position   = '0;
		w.progressed = 1'b0;
		if (chan < N_CHAN) begin
			if (kind == mcqd_pkg::KIND_SAMPLE) begin
				if (enc_enable[chan]) begin
					moved = enc_prev_ab[chan] ^ ab;
					slope = STEP_OF[{enc_prev_ab[chan], ab}];
					if (moved == BOTH_PINS) begin
						// skipped state: repeat the remembered step, if any
						case (enc_heading[chan])
							HEAD_UP:   enc_count[chan] = enc_count[chan] + 32'd1;
							HEAD_DOWN: enc_count[chan] = enc_count[chan] - 32'd1;
							default:   ;
						endcase
						enc_prev_ab[chan] = ab;
						w.progressed      = 1'b1;
					end else if (moved != NO_CHANGE) begin
						enc_prev_ab[chan] = ab;
						if (slope != 0) begin
							enc_count[chan]   = enc_count[chan] + slope;
							enc_heading[chan] = (slope > 0) ? HEAD_UP : HEAD_DOWN;
							w.progressed      = 1'b1;
						end
					end
				end
			end else if (kind == mcqd_pkg::KIND_CLEAR) begin
				// clear works on disabled channels too
				enc_count[chan]   = '0;
				enc_heading[chan] = HEAD_NONE;
				enc_prev_ab[chan] = ab;
			end
			w.position = enc_count[chan];
		end
		return w;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (full_rate || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(16, 40);
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		if (mismatches < MAX_PRINTS)
			$display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
		mismatches++;
	endtask

	// drive one word, wait for its handshake, then book the expected result
	task automatic send_word(mcqd_pkg::kind_t kind, logic [1:0] chan, logic [1:0] ab,
	                         bit typed, decode_word_t typed_word);
		int           gap;
		decode_word_t want;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0000, ab, chan};
		s_tuser  <= kind;
		do @(posedge clk); while (s_tready !== 1'b1);
		want = decode_step(kind, chan, ab);
		pending_words.push_back(typed ? typed_word : want);
	endtask

	// mask write only once every booked result is back
	task automatic load_mask(logic [3:0] mask);
		s_tvalid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= mask;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		enc_enable = mask;
	endtask

	// result side: random stalls, with full-rate stretches
	initial begin
		int hold;
		m_tready <= 1'b0;
		forever begin
			if (full_rate) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				hold = pick_gap();
				if (hold > 0) begin
					m_tready <= 1'b0;
					repeat (hold) @(posedge clk);
				end
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// every accepted result word against the oldest booked one
	always @(posedge clk) begin
		decode_word_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected word, channel", m_tdata[1:0], -1);
			end else begin
				want = pending_words.pop_front();
				if (m_tdata[1:0] !== want.chan)
					report_mismatch("channel_out", m_tdata[1:0], want.chan);
				if (m_tdata[33:2] !== want.position)
					report_mismatch("position", $signed(m_tdata[33:2]), want.position);
				if (m_tuser[0] !== want.progressed)
					report_mismatch("progressed", m_tuser[0], want.progressed);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		decode_word_t    typed_word;
		decode_word_t    unused_word;
		bit              walk_up [N_CHAN];
		mcqd_pkg::kind_t kind;
		logic [1:0]      chan;
		logic [1:0]      ab;
		logic [1:0]      cur;
		logic [3:0]      mask;
		int              r;
		int              spot;
		int              useful;
		int              raw;

		full_rate   = 1'b0;
		unused_word = '0;
		for (int c = 0; c < N_CHAN; c++) begin
			enc_count[c]   = '0;
			enc_prev_ab[c] = '0;
			enc_heading[c] = HEAD_NONE;
			walk_up[c]     = 1'b1;
		end
		enc_enable = '0;

		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= mcqd_pkg::KIND_SAMPLE;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, every expected word typed in
		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].load)
				load_mask(DIRECTED[i].mask);
			typed_word.chan       = DIRECTED[i].chan;
			typed_word.position   = DIRECTED[i].position;
			typed_word.progressed = DIRECTED[i].progressed;
			send_word(DIRECTED[i].kind, DIRECTED[i].chan, DIRECTED[i].ab, 1'b1, typed_word);
		end

		// random encoder walks, one enable mask per phase
		for (int phase = 0; phase < 8; phase++) begin
			mask = (phase == 2) ? 4'($urandom_range(1, 14)) : PHASE_MASK[phase];
			load_mask(mask);
			full_rate = (phase == 3 || phase == 6);
			useful    = 0;
			raw       = 0;
			while (useful < PHASE_WORDS && raw < 4 * PHASE_WORDS) begin
				chan = 2'($urandom_range(0, N_CHAN - 1));
				cur  = enc_prev_ab[chan];
				r    = $urandom_range(0, 99);
				kind = mcqd_pkg::KIND_SAMPLE;
				if (r < 68) begin
					// one gray step, direction mostly kept
					if ($urandom_range(0, 9) == 0)
						walk_up[chan] = ~walk_up[chan];
					spot = 0;
					for (int g = 0; g < 4; g++)
						if (GRAY[g] == cur)
							spot = g;
					ab = walk_up[chan] ? GRAY[(spot + 1) % 4] : GRAY[(spot + 3) % 4];
				end else if (r < 78) begin
					ab = cur;
				end else if (r < 86) begin
					ab = cur ^ BOTH_PINS;
				end else begin
					ab = 2'($urandom_range(0, 3));
					if (r < 92)
						kind = mcqd_pkg::KIND_CLEAR;
					else if (r < 97)
						kind = mcqd_pkg::KIND_READ;
					else
						kind = mcqd_pkg::KIND_RSVD;
				end
				// samples on disabled channels do not count toward the phase
				if (!(kind == mcqd_pkg::KIND_SAMPLE && !enc_enable[chan]))
					useful++;
				raw++;
				send_word(kind, chan, ab, 1'b0, unused_word);
			end
		end

		// drain, then watch for any stray word
		s_tvalid  <= 1'b0;
		full_rate = 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* filelist.f */
sv/mcqd_pkg.sv
sv/mcqd_chan_bank.sv
sv/mcqd_step.sv
sv/multi_channel_quadrature_decoder_top.sv
sim/multi_channel_quadrature_decoder_top_tb.sv
